// ===== rtl/wsdf_pkg.sv =====
package wsdf_pkg;

  localparam int LENGTH_BITS = 32;

  localparam logic [6:0] LEN_FIELD_MASK = 7'h7F;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES = 3'd2;
  // eight bytes wrap the 3-bit counter back to zero
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] MASK_LAST   = 3'd3;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LENBYTE = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef logic [LENGTH_BITS-1:0] len_t;

endpackage

// ===== rtl/websocket_frame_deframer_unit.sv =====
// a payload byte or empty-frame marker is registered and appears in the cycle after its input item is taken
// throughput: one input item per cycle unless a result waits; then header and mask items that
// make no result are still taken, the result register holds one item until out_ready takes it
// reset (rst, synchronous, active high) returns the parser to the first header byte
// and clears length, mask and the result valid flag
module websocket_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] payload_byte,
  output logic       frame_last,
  output logic       frame_empty,
  output logic       out_valid,
  input  logic       out_ready
);
  import wsdf_pkg::*;

  phase_t     phase, phase_next;
  logic [6:0] length_code, length_code_next;
  logic [2:0] header_byte_count, header_byte_count_next;
  len_t       payload_remaining, payload_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0] mask_position, mask_position_next;

  logic       produce;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_empty;
  logic [7:0] key_byte;
  logic [2:0] cnt_inc;
  logic       accept;

  assign produce = (phase == PH_PAYLOAD) ||
                   (phase == PH_MASK && header_byte_count == MASK_LAST &&
                    payload_remaining == '0);
  assign in_ready = !produce || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = header_byte_count + 3'd1;
  assign key_byte = 8'(mask_key >> {~mask_position, 3'b000});

  // next state
  always_comb begin
    phase_next             = phase;
    length_code_next       = length_code;
    header_byte_count_next = header_byte_count;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    mask_position_next     = mask_position;
    case (phase)
      PH_LENBYTE: begin
        length_code_next       = in_byte[6:0] & LEN_FIELD_MASK;
        header_byte_count_next = '0;
        mask_key_next          = '0;
        mask_position_next     = '0;
        if (length_code_next == LEN_CODE_EXT16 || length_code_next == LEN_CODE_EXT64) begin
          payload_remaining_next = '0;
          phase_next             = PH_EXTLEN;
        end else begin
          payload_remaining_next = len_t'(length_code_next);
          phase_next             = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        payload_remaining_next = len_t'({payload_remaining, in_byte});
        header_byte_count_next = cnt_inc;
        if (cnt_inc == ((length_code == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
          header_byte_count_next = '0;
          phase_next             = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_next          = {mask_key[23:0], in_byte};
        header_byte_count_next = cnt_inc;
        if (header_byte_count == MASK_LAST) begin
          header_byte_count_next = '0;
          mask_position_next     = '0;
          phase_next = (payload_remaining == '0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        payload_remaining_next = payload_remaining - len_t'(1);
        mask_position_next     = mask_position + 2'd1;
        if (payload_remaining_next == '0) begin
          phase_next = PH_FIRST;
        end
      end
      default: begin
        phase_next = PH_LENBYTE;
      end
    endcase
  end

  // result
  always_comb begin
    res_byte  = '0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    case (phase)
      PH_MASK: begin
        res_last  = 1'b1;
        res_empty = 1'b1;
      end
      PH_PAYLOAD: begin
        res_byte = in_byte ^ key_byte;
        res_last = (payload_remaining == len_t'(1));
      end
      default: begin
        res_byte = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FIRST;
      length_code       <= '0;
      header_byte_count <= '0;
      payload_remaining <= '0;
      mask_key          <= '0;
      mask_position     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        length_code       <= length_code_next;
        header_byte_count <= header_byte_count_next;
        payload_remaining <= payload_remaining_next;
        mask_key          <= mask_key_next;
        mask_position     <= mask_position_next;
      end
      if (accept && produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      payload_byte <= res_byte;
      frame_last   <= res_last;
      frame_empty  <= res_empty;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_empty |-> frame_last && payload_byte == 8'd0)
    else $error("empty frame item without last flag or with data");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_remaining != '0)
    else $error("payload phase with nothing remaining");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MASK |-> header_byte_count <= MASK_LAST)
    else $error("mask byte count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_last))
    else $error("pending result overwritten or dropped");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import wsdf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } deframe_res_t;

  typedef enum int {LF_DIRECT, LF_EXT16, LF_EXT64} len_form_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] in_byte = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic       frame_empty;
  logic       out_valid;
  logic       out_ready = 1'b0;

  websocket_frame_deframer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_byte(in_byte),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .payload_byte(payload_byte),
    .frame_last(frame_last),
    .frame_empty(frame_empty),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // predictor state
  phase_t       fr_phase;
  logic [6:0]   fr_code;
  logic [2:0]   fr_cnt;
  len_t         fr_left;
  logic [31:0]  fr_mask;
  logic [1:0]   fr_pos;
  deframe_res_t expected_payload[$];

  int err_cnt = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic void queue_expected(input deframe_res_t r);
    expected_payload = {expected_payload, r};
  endfunction

  function automatic void deframe_step(input logic [7:0] b);
    deframe_res_t r;
    logic [2:0]   need;
    logic [7:0]   key;
    case (fr_phase)
      PH_LENBYTE: begin
        fr_code = b[6:0] & LEN_FIELD_MASK;
        fr_cnt  = '0;
        fr_mask = '0;
        fr_pos  = '0;
        if (fr_code == LEN_CODE_EXT16 || fr_code == LEN_CODE_EXT64) begin
          fr_left  = '0;
          fr_phase = PH_EXTLEN;
        end else begin
          fr_left  = len_t'(fr_code);
          fr_phase = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        need    = (fr_code == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        fr_left = {fr_left[LENGTH_BITS-9:0], b};
        fr_cnt  = fr_cnt + 3'd1;
        if (fr_cnt == need) begin
          fr_cnt   = '0;
          fr_phase = PH_MASK;
        end
      end
      PH_MASK: begin
        fr_mask = {fr_mask[23:0], b};
        fr_cnt  = fr_cnt + 3'd1;
        if (fr_cnt == 3'd4) begin
          fr_cnt = '0;
          fr_pos = '0;
          if (fr_left == '0) begin
            fr_phase = PH_FIRST;
            r = '{data: 8'h00, last: 1'b1, empty: 1'b1};
            queue_expected(r);
          end else begin
            fr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        key     = fr_mask[(3 - fr_pos) * 8 +: 8];
        fr_left = fr_left - len_t'(1);
        fr_pos  = fr_pos + 2'd1;
        r.data  = b ^ key;
        r.last  = (fr_left == '0);
        r.empty = 1'b0;
        queue_expected(r);
        if (fr_left == '0) begin
          fr_phase = PH_FIRST;
        end
      end
      default: begin
        fr_phase = PH_LENBYTE;
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_proc
    deframe_res_t exp_r;
    if (rst) begin
      fr_phase = PH_FIRST;
      fr_code  = '0;
      fr_cnt   = '0;
      fr_left  = '0;
      fr_mask  = '0;
      fr_pos   = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_payload.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, exp none got %02h last %b empty %b",
                   $time, payload_byte, frame_last, frame_empty);
        end else begin
          exp_r = expected_payload.pop_front();
          if (payload_byte !== exp_r.data) begin
            err_cnt++;
            $display("%0t: payload_byte exp %02h got %02h", $time, exp_r.data, payload_byte);
          end
          if (frame_last !== exp_r.last) begin
            err_cnt++;
            $display("%0t: frame_last exp %b got %b", $time, exp_r.last, frame_last);
          end
          if (frame_empty !== exp_r.empty) begin
            err_cnt++;
            $display("%0t: frame_empty exp %b got %b", $time, exp_r.empty, frame_empty);
          end
        end
      end
      if (in_valid && in_ready) begin
        deframe_step(in_byte);
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_cycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame(input len_form_t form, input int unsigned len,
                            input logic [31:0] high_len, input logic [31:0] key);
    logic [6:0] code;
    logic       mbit;
    mbit = 1'($urandom_range(1));
    case (form)
      LF_EXT16: code = LEN_CODE_EXT16;
      LF_EXT64: code = LEN_CODE_EXT64;
      default:  code = len[6:0];
    endcase
    send_byte(8'($urandom_range(255)));
    send_byte({mbit, code});
    if (form == LF_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == LF_EXT64) begin
      for (int i = 3; i >= 0; i--) send_byte(high_len[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) send_byte(len[i*8 +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[i*8 +: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic test_empty_and_long_frames;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(LF_DIRECT, 0, 32'h0, 32'h0000_0000);
    // upper half of a 64-bit length is dropped
    send_frame(LF_EXT64, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_frames(input int target, input int s_pct, input int r_pct);
    int          stop_at;
    int          pick;
    len_form_t   form;
    int unsigned len;
    logic [31:0] high_len;
    logic [31:0] key;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        form = LF_DIRECT;
        pick = $urandom_range(99);
        if (pick < 55) len = $urandom_range(8);
        else if (pick < 85) len = $urandom_range(40, 9);
        else if (pick < 93) len = $urandom_range(125);
        else len = 125;
      end else if (pick < 90) begin
        form = LF_EXT16;
        len  = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(12);
      end else begin
        form = LF_EXT64;
        len  = $urandom_range(60);
      end
      high_len = $urandom_range(1) ? $urandom : 32'h0;
      pick = $urandom_range(9);
      if (pick == 0) key = 32'h0000_0000;
      else if (pick == 1) key = 32'hFFFF_FFFF;
      else key = $urandom;
      send_frame(form, len, high_len, key);
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 200;
    hold_req++;
    send_frame(LF_EXT16, 150, 32'h0, $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_long_frames();
    test_random_frames(280, 32, 54);
    test_random_frames(280, 54, 32);
    test_backpressure();
    test_random_frames(280, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
